// File: design/wildcard_regex_matcher_macros.svh
// Assertion macros shared by the wildcard matcher checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef WILDCARD_REGEX_MATCHER_MACROS_SVH
`define WILDCARD_REGEX_MATCHER_MACROS_SVH

// same-cycle implication
`define WRM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/wrm_pkg.sv
// Package for the wildcard matcher: request codes, pattern characters,
// widths and the per-cell control struct. No dependencies.
package wrm_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int CFG_W           = 6;
	localparam int PAT_IDX_W       = 5;
	localparam int BYTE_W          = 8;

	localparam logic [BYTE_W-1:0] CH_STAR = 8'd42;
	localparam logic [BYTE_W-1:0] CH_DOT  = 8'd46;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_START = 2'd1,
		REQ_TEXT  = 2'd2
	} req_type_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic              start;
		logic              step;
		logic [BYTE_W-1:0] text_char;
	} wrm_ctl_t;

endpackage

// File: design/wrm_cell.sv
// One cell of the match row: holds one pattern byte and one row bit.
// Depends on wrm_pkg.
module wrm_cell #(
	parameter bit FIRST = 1'b0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wrm_pkg::wrm_ctl_t         ctl,
	input  logic                      active,
	input  logic                      wr_en,
	input  logic [wrm_pkg::BYTE_W-1:0] wr_byte,
	input  logic [wrm_pkg::BYTE_W-1:0] prev_byte,
	input  logic                      new_m1,
	input  logic                      new_m2,
	input  logic                      old_m1,
	output logic                      new_bit,
	output logic                      row_bit,
	output logic [wrm_pkg::BYTE_W-1:0] pat_byte
);
	import wrm_pkg::*;

	logic [BYTE_W-1:0] pat_q;
	logic              row_q;
	logic              is_star;
	logic              prev_ok;
	logic              own_ok;

	assign is_star = (pat_q == CH_STAR);
	assign prev_ok = (ctl.text_char == prev_byte) || (prev_byte == CH_DOT);
	assign own_ok  = (pat_q == CH_DOT) || (pat_q == ctl.text_char);

	// next row bit; a star in the first position never matches
	always_comb begin
		new_bit = 1'b0;
		if (active) begin
			if (ctl.start) begin
				new_bit = !FIRST && is_star && new_m2;
			end else if (is_star) begin
				new_bit = !FIRST && (new_m1 || new_m2 || (row_q && prev_ok));
			end else begin
				new_bit = old_m1 && own_ok;
			end
		end
	end

	// row bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 1'b0;
		end else if (ctl.start || ctl.step) begin
			row_q <= new_bit;
		end
	end

	// pattern byte, undefined until loaded
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q <= wr_byte;
		end
	end

	assign row_bit  = row_q;
	assign pat_byte = pat_q;

endmodule

// File: design/wildcard_regex_matcher.sv
// Top level of the streaming dot/star pattern matcher: a row of match cells.
// Depends on wrm_pkg and wrm_cell.
//
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, req_type, pattern_index,| into block
//          | pattern_byte, text_char                   |
//  out     | out_valid/out_ready, matched              | out of block
//  cfg     | cfg_valid/cfg_ready, pattern_length       | into block
//
// One transaction per cycle on the input while in_ready is high; a start or text
// byte gives its result from the output register in the cycle after acceptance.
// The row update ripples combinationally through all cells in the cycle of acceptance.
// in_ready drops only while a result is held and out_ready is low.
// Reset clears the row, the length and the output valid; pattern bytes
// stay undefined until loaded. cfg_ready is always high.
module wildcard_regex_matcher #(
	parameter int PATTERN_MAX = wrm_pkg::PATTERN_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [wrm_pkg::PAT_IDX_W-1:0] pattern_index,
	input  logic [wrm_pkg::BYTE_W-1:0]    pattern_byte,
	input  logic [wrm_pkg::BYTE_W-1:0]    text_char,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          matched,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wrm_pkg::CFG_W-1:0]     pattern_length
);
	import wrm_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic [LEN_W-1:0]   len_q;
	logic               row0_q;
	logic               out_valid_q;
	logic               matched_q;
	logic               in_acc;
	logic               load_en;
	logic               has_result;
	req_type_t          req;
	wrm_ctl_t           ctl;
	logic [PATTERN_MAX:0] new_row;
	logic [PATTERN_MAX:0] cur_row;
	logic [BYTE_W-1:0]  cell_byte [1:PATTERN_MAX];

	// handshake
	assign req        = req_type_t'(req_type);
	assign in_ready   = !out_valid_q || out_ready;
	assign in_acc     = in_valid && in_ready;
	assign load_en    = in_acc && (req == REQ_LOAD);
	assign has_result = (req == REQ_START) || (req == REQ_TEXT);

	assign ctl.start     = in_acc && (req == REQ_START);
	assign ctl.step      = in_acc && (req == REQ_TEXT);
	assign ctl.text_char = text_char;

	// effective pattern length, clamped to the cell count
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_valid) begin
			if (pattern_length > CFG_W'(PATTERN_MAX)) begin
				len_q <= LEN_W'(PATTERN_MAX);
			end else begin
				len_q <= LEN_W'(pattern_length);
			end
		end
	end

	// row bit zero: set by start, cleared by any text byte
	assign new_row[0] = ctl.start;
	assign cur_row[0] = row0_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= 1'b0;
		end else if (ctl.start || ctl.step) begin
			row0_q <= ctl.start;
		end
	end

	// cell row, position j holds pattern byte j-1
	for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
		logic              active;
		logic              wr_en;
		logic [BYTE_W-1:0] prev_byte;
		logic              new_m2;

		assign active = (LEN_W'(j) <= len_q);
		assign wr_en  = load_en && (CFG_W'(pattern_index) == CFG_W'(j - 1));

		if (j == 1) begin : g_head
			assign prev_byte = '0;
			assign new_m2    = 1'b0;
		end else begin : g_body
			assign prev_byte = cell_byte[j-1];
			assign new_m2    = new_row[j-2];
		end

		wrm_cell #(
			.FIRST (j == 1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.active    (active),
			.wr_en     (wr_en),
			.wr_byte   (pattern_byte),
			.prev_byte (prev_byte),
			.new_m1    (new_row[j-1]),
			.new_m2    (new_m2),
			.old_m1    (cur_row[j-1]),
			.new_bit   (new_row[j]),
			.row_bit   (cur_row[j]),
			.pat_byte  (cell_byte[j])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_result) begin
			matched_q <= new_row[len_q];
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

endmodule

// File: design/wrm_checker.sv
// Port-level checker for wildcard_regex_matcher, bound to the top level.
// Depends on wrm_pkg and wildcard_regex_matcher_macros.svh.
`include "wildcard_regex_matcher_macros.svh"

module wrm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [1:0]                    req_type,
	input logic [wrm_pkg::PAT_IDX_W-1:0] pattern_index,
	input logic [wrm_pkg::BYTE_W-1:0]    pattern_byte,
	input logic [wrm_pkg::BYTE_W-1:0]    text_char,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          matched,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [wrm_pkg::CFG_W-1:0]     pattern_length
);
	import wrm_pkg::*;

	logic in_acc;
	logic gives_result;

	assign in_acc       = in_valid && in_ready;
	assign gives_result = (req_type == REQ_START) || (req_type == REQ_TEXT);

	// a held result stays put until taken
	`WRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(matched), "result dropped or changed while stalled")

	// a full output register with no taker blocks input
	`WRM_ASSERT_NOW(a_backpressure, out_valid && !out_ready, !in_ready, "input accepted while result stalled")

	// start and text transactions always produce a result
	`WRM_ASSERT_NEXT(a_result_made, in_acc && gives_result, out_valid, "missing result")

	// loads and unused codes produce none
	`WRM_ASSERT_NEXT(a_no_result, in_acc && !gives_result && (!out_valid || out_ready), !out_valid, "spurious result")

endmodule

bind wildcard_regex_matcher wrm_checker u_wrm_checker (.*);

// File: sim/testbench.sv
// Self-checking testbench for wildcard_regex_matcher (dot/star streaming matcher).
// Depends on wrm_pkg and the matcher RTL. Keeps its own copy of the match row
// and pattern store, and checks every matched result in order.
`timescale 1ns / 100ps

module testbench;
	import wrm_pkg::*;

	localparam int PM            = PATTERN_MAX_DEF;
	localparam int ITEM_GOAL     = 2000;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int HOLD_CYCLES   = 200;
	localparam int HOLD_AT       = 400;
	localparam int TAIL_CYCLES   = 10;
	localparam int IDLE_PCT      = 21;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Tracks pattern bytes, length and match row; queues expected matched bits
	class match_tracker;
		bit [BYTE_W-1:0] pat_mem [PM];
		logic [PM:0]     row;
		logic [CFG_W-1:0] plen;
		bit              expected_matches [$];
		int errors, n_checked, n_load, n_start, n_text, n_ignored;

		function new();
			foreach (pat_mem[i]) pat_mem[i] = '0;
			row = '0;
			plen = '0;
		endfunction

		function void set_pattern_length(logic [CFG_W-1:0] v);
			plen = v;
		endfunction

		function int eff_len();
			return (plen > PM) ? PM : int'(plen);
		endfunction

		function int pending();
			return expected_matches.size();
		endfunction

		// row for empty text: only star pairs can match nothing
		function logic [PM:0] empty_text_row(int len);
			logic [PM:0] r;
			r = '0;
			r[0] = 1'b1;
			for (int j = 2; j <= len; j++)
				if (pat_mem[j-1] == CH_STAR && r[j-2])
					r[j] = 1'b1;
			return r;
		endfunction

		// one step of the recurrence for text byte c
		function logic [PM:0] advance_row(logic [PM:0] old, int len, logic [BYTE_W-1:0] c);
			logic [PM:0] nxt;
			logic [BYTE_W-1:0] pj, prev;
			logic b;
			nxt = '0;
			for (int j = 1; j <= len; j++) begin
				pj = pat_mem[j-1];
				if (pj == CH_STAR) begin
					if (j < 2) begin
						b = 1'b0; // leading star never matches
					end else begin
						prev = pat_mem[j-2];
						b = nxt[j-1] | nxt[j-2] | (old[j] & ((c == prev) || (prev == CH_DOT)));
					end
				end else begin
					b = old[j-1] & ((pj == CH_DOT) || (pj == c));
				end
				nxt[j] = b;
			end
			return nxt;
		endfunction

		function void note_request(logic [1:0] req, logic [PAT_IDX_W-1:0] idx,
				logic [BYTE_W-1:0] pb, logic [BYTE_W-1:0] tc);
			int len;
			len = eff_len();
			case (req)
				REQ_LOAD: begin
					pat_mem[idx] = pb;
					n_load++;
				end
				REQ_START: begin
					row = empty_text_row(len);
					expected_matches.push_back(row[len]);
					n_start++;
				end
				REQ_TEXT: begin
					row = advance_row(row, len, tc);
					expected_matches.push_back(row[len]);
					n_text++;
				end
				default: n_ignored++;
			endcase
		endfunction

		// one line per mismatch; quiet after the first hundred
		task report(string msg);
			if (errors < 100)
				$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		task check_match(logic m);
			bit e;
			if (expected_matches.size() == 0) begin
				report($sformatf("matched=%b with no transaction pending", m));
			end else begin
				e = expected_matches.pop_front();
				n_checked++;
				if (m !== e)
					report($sformatf("result %0d: matched=%b, expected %b", n_checked, m, e));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] req_type;
	logic [PAT_IDX_W-1:0] pattern_index;
	logic [BYTE_W-1:0] pattern_byte;
	logic [BYTE_W-1:0] text_char;
	logic out_valid;
	logic out_ready;
	logic matched;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] pattern_length;

	match_tracker sb;
	bit [PM-1:0] loaded;
	int cur_len;
	int items_sent;
	int max_len_written;
	int cycles;
	int hold_left;
	bit hold_done;
	logic steady;

	wildcard_regex_matcher u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.pattern_index (pattern_index),
		.pattern_byte  (pattern_byte),
		.text_char     (text_char),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.matched       (matched),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.pattern_length(pattern_length)
	);

	// clock, 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("wildcard_regex_matcher verification failed");
			$finish;
		end
	end

	// result side: check, then pick out_ready; one long hold-off mid-run
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_match(matched);
			if (!hold_done && sb.n_checked >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	function automatic logic [BYTE_W-1:0] pick_atom();
		int r;
		r = $urandom_range(99);
		if (r < 35) return "a";
		if (r < 60) return "b";
		if (r < 70) return "c";
		if (r < 90) return CH_DOT;
		if (r < 95) return CH_STAR;
		return BYTE_W'($urandom_range(255));
	endfunction

	function automatic logic [BYTE_W-1:0] pick_text();
		int r;
		r = $urandom_range(99);
		if (r < 40) return "a";
		if (r < 70) return "b";
		if (r < 80) return "c";
		if (r < 85) return CH_DOT;
		if (r < 90) return CH_STAR;
		return BYTE_W'($urandom_range(255));
	endfunction

	// one input transaction; valid stays high after acceptance until the caller lowers it
	task automatic send_item(logic [1:0] req, logic [PAT_IDX_W-1:0] idx,
			logic [BYTE_W-1:0] pb, logic [BYTE_W-1:0] tc);
		if (!steady)
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid      <= 1'b1;
		req_type      <= req;
		pattern_index <= idx;
		pattern_byte  <= pb;
		text_char     <= tc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(req, idx, pb, tc);
		if (req != REQ_UNUSED)
			items_sent++;
	endtask

	task automatic load_byte(int idx, logic [BYTE_W-1:0] b);
		send_item(REQ_LOAD, idx[PAT_IDX_W-1:0], b, BYTE_W'($urandom_range(255)));
		loaded[idx] = 1'b1;
	endtask

	// never let the block read a pattern byte that was not loaded
	task automatic fill_gaps();
		for (int i = 0; i < cur_len; i++)
			if (!loaded[i])
				load_byte(i, pick_atom());
	endtask

	task automatic start_text();
		fill_gaps();
		send_item(REQ_START, PAT_IDX_W'($urandom_range(31)), BYTE_W'($urandom_range(255)),
			BYTE_W'($urandom_range(255)));
	endtask

	task automatic text_byte(logic [BYTE_W-1:0] c);
		fill_gaps();
		send_item(REQ_TEXT, PAT_IDX_W'($urandom_range(31)), BYTE_W'($urandom_range(255)), c);
	endtask

	task automatic ignored_item();
		send_item(REQ_UNUSED, PAT_IDX_W'($urandom_range(31)), BYTE_W'($urandom_range(255)),
			BYTE_W'($urandom_range(255)));
	endtask

	// length write only with the block drained
	task automatic write_length(logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid      <= 1'b1;
		pattern_length <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_pattern_length(v);
		cfg_valid <= 1'b0;
		cur_len = (v > PM) ? PM : int'(v);
		if (int'(v) > max_len_written)
			max_len_written = int'(v);
	endtask

	// pattern as atoms, some followed by a star
	task automatic load_pattern(int len);
		int pos;
		pos = 0;
		while (pos < len) begin
			load_byte(pos, pick_atom());
			pos++;
			if (pos < len && $urandom_range(99) < 35) begin
				load_byte(pos, CH_STAR);
				pos++;
			end
		end
	endtask

	// main sequence
	initial begin
		int phase, budget, r, goal;
		logic [CFG_W-1:0] v;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		pattern_index = '0;
		pattern_byte = '0;
		text_char = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		pattern_length = '0;
		steady = 1'b0;
		loaded = '0;
		cur_len = 0;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: text before start, empty pattern
		text_byte("a");
		start_text();
		text_byte(8'hFF);
		// leading star
		write_length(6'd1);
		load_byte(0, CH_STAR);
		start_text();
		text_byte(CH_STAR);
		// star after star
		write_length(6'd3);
		load_byte(0, "a");
		load_byte(1, CH_STAR);
		load_byte(2, CH_STAR);
		start_text();
		text_byte("a");
		text_byte("a");
		text_byte("b");
		// dot-star against byte extremes
		write_length(6'd2);
		load_byte(0, CH_DOT);
		load_byte(1, CH_STAR);
		start_text();
		text_byte(8'h00);
		text_byte(8'hFF);
		// length grows in the middle of a text
		load_byte(2, "a");
		load_byte(3, "b");
		write_length(6'd4);
		text_byte("a");
		text_byte("b");
		ignored_item();
		load_byte(31, 8'hFF);
		load_byte(4, 8'h00);

		// random phases
		goal = items_sent + ITEM_GOAL;
		phase = 0;
		while (items_sent < goal) begin
			r = $urandom_range(99);
			if (phase == 0)
				v = 6'd63;  // oversized, clamps to the maximum
			else if (phase == 1)
				v = CFG_W'(PM);
			else if (r < 10)
				v = CFG_W'($urandom_range(63, PM + 1));
			else if (r < 25)
				v = CFG_W'($urandom_range(PM, 0));
			else
				v = CFG_W'($urandom_range(8, 0));
			write_length(v);
			steady <= (phase >= 6 && phase < 11);
			if (phase < 2 || $urandom_range(99) < 70) begin
				load_pattern(cur_len);
				start_text();
			end
			budget = $urandom_range(80, 20);
			repeat (budget) begin
				r = $urandom_range(99);
				if (r < 10)
					start_text();
				else if (r < 80)
					text_byte(pick_text());
				else if (r < 88)
					load_byte($urandom_range(PM - 1), pick_atom());
				else if (r < 94)
					ignored_item();
				else
					text_byte(BYTE_W'($urandom_range(255)));
			end
			phase++;
		end
		in_valid <= 1'b0;

		// drain, then a short tail for stray results
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d phases: %0d loads, %0d starts, %0d text bytes, %0d unused requests",
			phase, sb.n_load, sb.n_start, sb.n_text, sb.n_ignored);
		$display("Checked %0d results, lengths written up to %0d, %0d mismatches",
			sb.n_checked, max_len_written, sb.errors);
		if (sb.errors == 0)
			$display("wildcard_regex_matcher verification clean");
		else
			$display("wildcard_regex_matcher verification failed");
		$finish;
	end

endmodule
